[sv/tsfc_pkg.sv]
package tsfc_pkg;

    localparam int AXIS_BITS_DEF = 16;
    localparam int FIELD_W       = 16;
    localparam int LEVEL_W       = 14;
    localparam int HOLD_W        = 16;
    localparam int TIME_W        = 32;
    localparam int CODE_W        = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int IN_DATA_W     = 80;
    localparam int OUT_DATA_W    = 8;

    localparam logic [LEVEL_W-1:0] FREE_FALL_RST = LEVEL_W'(77);
    localparam logic [LEVEL_W-1:0] SLAM_RST      = LEVEL_W'(768);
    localparam logic [LEVEL_W-1:0] BUMP_RST      = LEVEL_W'(384);
    localparam logic [LEVEL_W-1:0] TILT_RST      = LEVEL_W'(128);
    localparam logic [HOLD_W-1:0]  HOLD_RST      = HOLD_W'(1000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FREE_FALL = 3'd0,
        CFG_SLAM      = 3'd1,
        CFG_BUMP      = 3'd2,
        CFG_TILT      = 3'd3,
        CFG_HOLD      = 3'd4
    } t_cfg_idx;

    typedef enum logic [CODE_W-1:0] {
        EV_NONE   = 3'd0,
        EV_BUMP   = 3'd1,
        EV_WARN   = 3'd2,
        EV_TILT   = 3'd3,
        EV_SLAM   = 3'd4,
        EV_FALL   = 3'd5,
        EV_STABLE = 3'd6
    } t_event;

    typedef struct packed {
        logic [LEVEL_W-1:0] free_fall_level;
        logic [LEVEL_W-1:0] slam_level;
        logic [LEVEL_W-1:0] bump_level;
        logic [LEVEL_W-1:0] tilt_level;
        logic [HOLD_W-1:0]  tilt_hold_ms;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic clear;
    } t_warn_upd;

endpackage

[sv/tsfc_decide.sv]
module tsfc_decide
    import tsfc_pkg::*;
#(
    parameter int AXIS_BITS = AXIS_BITS_DEF
) (
    input  logic [AXIS_BITS-1:0] i_x,
    input  logic [AXIS_BITS-1:0] i_y,
    input  logic [AXIS_BITS-1:0] i_z,
    input  logic [TIME_W-1:0]    i_now,
    input  t_cfg                 i_cfg,
    input  logic                 i_warn_active,
    input  logic [TIME_W-1:0]    i_warn_start,
    output t_event               o_code,
    output t_warn_upd            o_upd
);

    localparam int SQ_W  = 2 * AXIS_BITS;
    localparam int MAG_W = SQ_W + 2;
    localparam int FF_W  = 2 * LEVEL_W;
    localparam int CMP_W = (MAG_W > FF_W) ? MAG_W : FF_W;
    localparam int VAL_W = ((AXIS_BITS > LEVEL_W) ? AXIS_BITS : LEVEL_W) + 1;

    logic signed [AXIS_BITS-1:0] ax, ay, az;
    logic signed [SQ_W-1:0]      sq_x, sq_y, sq_z;
    logic [MAG_W-1:0]            mag2;
    logic [FF_W-1:0]             ff2;
    logic                        is_fall;
    logic [AXIS_BITS-1:0]        vert;
    logic signed [AXIS_BITS-1:0] lat;
    logic signed [VAL_W-1:0]     vert_e, lat_e, slam_e, bump_e, tilt_e;
    logic [TIME_W-1:0]           elapsed;

    assign ax = signed'(i_x);
    assign ay = signed'(i_y);
    assign az = signed'(i_z);

    assign sq_x = ax * ax;
    assign sq_y = ay * ay;
    assign sq_z = az * az;
    assign mag2 = {2'b00, sq_x} + {2'b00, sq_y} + {2'b00, sq_z};
    assign ff2  = i_cfg.free_fall_level * i_cfg.free_fall_level;
    assign is_fall = CMP_W'(mag2) < CMP_W'(ff2);

    assign vert = i_z[AXIS_BITS-1] ? (~i_z + 1'b1) : i_z;
    assign lat  = (ax > ay) ? ax : ay;

    assign vert_e = signed'(VAL_W'(vert));
    assign lat_e  = VAL_W'(lat);
    assign slam_e = signed'(VAL_W'(i_cfg.slam_level));
    assign bump_e = signed'(VAL_W'(i_cfg.bump_level));
    assign tilt_e = signed'(VAL_W'(i_cfg.tilt_level));

    assign elapsed = i_now - i_warn_start;

    always_comb begin
        o_code      = EV_NONE;
        o_upd.start = 1'b0;
        o_upd.clear = 1'b0;
        priority if (is_fall) begin
            o_code      = EV_FALL;
            o_upd.clear = 1'b1;
        end else if (vert_e > slam_e || lat_e > slam_e) begin
            o_code      = EV_SLAM;
            o_upd.clear = 1'b1;
        end else if (vert_e > bump_e || lat_e > bump_e) begin
            o_code = EV_BUMP;
        end else if (lat_e > tilt_e) begin
            if (!i_warn_active) begin
                o_code      = EV_WARN;
                o_upd.start = 1'b1;
            end else if (elapsed >= TIME_W'(i_cfg.tilt_hold_ms)) begin
                o_code      = EV_TILT;
                o_upd.clear = 1'b1;
            end
        end else if (i_warn_active) begin
            o_code      = EV_STABLE;
            o_upd.clear = 1'b1;
        end else begin
            o_code = EV_NONE;
        end
    end

endmodule

[sv/tilt_shock_freefall_classifier.sv]
// throughput: one word per cycle unless m_axis_tready holds the output back,
// one input register and one result register
// with the tilt warning state updated in the same cycle as the result
// reset: synchronous active-low i_rst_n clears both stages and the warning state
// and restores the default thresholds and hold time
module tilt_shock_freefall_classifier
    import tsfc_pkg::*;
#(
    parameter int AXIS_BITS = AXIS_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // accel_x [15:0], accel_y [31:16], accel_z [47:32], now_ms [79:48]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // event_code [2:0], zero fill [7:3]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_cfg                 r_cfg;
    logic                 r_in_valid;
    logic [AXIS_BITS-1:0] r_x, r_y, r_z;
    logic [TIME_W-1:0]    r_now;
    logic                 r_out_valid;
    t_event               r_code;
    logic                 r_warn_active;
    logic [TIME_W-1:0]    r_warn_start;

    logic                 in_acc;
    logic                 advance;
    t_event               n_code;
    t_warn_upd            upd;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || !r_out_valid || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.free_fall_level <= FREE_FALL_RST;
            r_cfg.slam_level      <= SLAM_RST;
            r_cfg.bump_level      <= BUMP_RST;
            r_cfg.tilt_level      <= TILT_RST;
            r_cfg.tilt_hold_ms    <= HOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FREE_FALL: r_cfg.free_fall_level <= i_cfg_wdata[LEVEL_W-1:0];
                CFG_SLAM:      r_cfg.slam_level      <= i_cfg_wdata[LEVEL_W-1:0];
                CFG_BUMP:      r_cfg.bump_level      <= i_cfg_wdata[LEVEL_W-1:0];
                CFG_TILT:      r_cfg.tilt_level      <= i_cfg_wdata[LEVEL_W-1:0];
                CFG_HOLD:      r_cfg.tilt_hold_ms    <= i_cfg_wdata[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x   <= s_axis_tdata[AXIS_BITS-1:0];
            r_y   <= s_axis_tdata[FIELD_W+AXIS_BITS-1:FIELD_W];
            r_z   <= s_axis_tdata[2*FIELD_W+AXIS_BITS-1:2*FIELD_W];
            r_now <= s_axis_tdata[3*FIELD_W+TIME_W-1:3*FIELD_W];
        end
    end

    tsfc_decide #(
        .AXIS_BITS(AXIS_BITS)
    ) u_decide (
        .i_x          (r_x),
        .i_y          (r_y),
        .i_z          (r_z),
        .i_now        (r_now),
        .i_cfg        (r_cfg),
        .i_warn_active(r_warn_active),
        .i_warn_start (r_warn_start),
        .o_code       (n_code),
        .o_upd        (upd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warn_active <= 1'b0;
            r_warn_start  <= '0;
        end else if (advance) begin
            if (upd.start) begin
                r_warn_active <= 1'b1;
                r_warn_start  <= r_now;
            end else if (upd.clear) begin
                r_warn_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_code <= n_code;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-CODE_W){1'b0}}, r_code};

endmodule
